### hdl/midpoint_ellipse_rasterizer_top_defines.svh
// assertion macros for the midpoint ellipse rasterizer
// expects clk and rst_n in the scope where a macro is used
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_TOP_DEFINES_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MER_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("midpoint ellipse rasterizer: same-cycle check failed");

// next-cycle implication, checked outside reset
`define MER_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("midpoint ellipse rasterizer: next-cycle check failed");

`endif

### hdl/mer_pkg.sv
// shared constants for the midpoint ellipse rasterizer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mer_pkg;

    // default semi-axis width in bits
    localparam int AXIS_WIDTH_DEFAULT = 10;

    // decision value width, a two's complement integer scaled by 4
    localparam int DEC_W = 48;

    // width of the emitted coordinates
    localparam int POINT_W = 10;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SEMI_AXIS_X = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEMI_AXIS_Y = 1'd1;

    // semi-axis values after reset
    localparam int SEMI_AXIS_X_RESET = 200;
    localparam int SEMI_AXIS_Y_RESET = 100;

endpackage

`default_nettype wire

### hdl/midpoint_ellipse_rasterizer_top.sv
// midpoint ellipse rasterizer top level: sequencer around one shared multiplier
// depends on mer_pkg and midpoint_ellipse_rasterizer_top_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "midpoint_ellipse_rasterizer_top_defines.svh"

// Origin-centred midpoint ellipse rasterizer. Write the semi-axes a (index 0) and b
// (index 1), send a beat with restart set to load a new ellipse at (0,b), then one beat
// with restart clear per point: each gives one result beat with the first-quadrant point
// (mirror it to get the four plotted points), final_point on the point with y = 0, and
// point_valid clear once the ellipse is done or on the restart beat itself. All products
// go through one registered multiplier, one product per cycle: a restart beat steps
// through S_BB, S_AAB and S_PUT, an ordinary point through S_BB, S_BX, S_AY and S_PUT,
// the point where region one hands over to region two also through S_XX, S_UU, S_BXX,
// S_AUU, S_AABB and S_R2 back to S_PUT, and a beat after the end (or the y = 0 point)
// only through S_PUT, which waits while the result register stays stalled. The block takes
// a new input beat while the previous result still waits on the output.
module midpoint_ellipse_rasterizer_top #(
    parameter int AXIS_WIDTH = mer_pkg::AXIS_WIDTH_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration writes
    input  wire logic                          cfg_we,
    input  wire logic [mer_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [AXIS_WIDTH-1:0]         cfg_data,
    // input channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          restart,
    // output channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [mer_pkg::POINT_W-1:0]        point_x,
    output logic [mer_pkg::POINT_W-1:0]        point_y,
    output logic                               point_valid,
    output logic                               final_point
);

    localparam int SQ_W      = 2 * AXIS_WIDTH;
    localparam int DEC_W     = mer_pkg::DEC_W;
    localparam int POINT_W   = mer_pkg::POINT_W;
    localparam int MUL_EXT_W = 2 * SQ_W + DEC_W;

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_BB   = 4'd1;
    localparam logic [3:0] S_AAB  = 4'd2;
    localparam logic [3:0] S_BX   = 4'd3;
    localparam logic [3:0] S_AY   = 4'd4;
    localparam logic [3:0] S_PUT  = 4'd5;
    localparam logic [3:0] S_XX   = 4'd6;
    localparam logic [3:0] S_UU   = 4'd7;
    localparam logic [3:0] S_BXX  = 4'd8;
    localparam logic [3:0] S_AUU  = 4'd9;
    localparam logic [3:0] S_AABB = 4'd10;
    localparam logic [3:0] S_R2   = 4'd11;

    // kind of the item in flight
    localparam logic [1:0] K_RESTART = 2'd0;
    localparam logic [1:0] K_EMPTY   = 2'd1;
    localparam logic [1:0] K_STEP    = 2'd2;

    // configuration registers
    logic [AXIS_WIDTH-1:0] axis_a_reg;
    logic [AXIS_WIDTH-1:0] axis_b_reg;

    // control and ellipse state
    logic [3:0]            state_reg, state_next;
    logic [1:0]            kind_reg, kind_next;
    logic [AXIS_WIDTH-1:0] cur_x_reg, cur_x_next;
    logic [AXIS_WIDTH-1:0] cur_y_reg, cur_y_next;
    logic [DEC_W-1:0]      decision_reg, decision_next;
    logic                  region_two_reg, region_two_next;
    logic                  finished_reg, finished_next;
    logic                  out_valid_reg, out_valid_next;

    // products held between multiplier passes
    logic [SQ_W-1:0]       aa_reg;
    logic [SQ_W-1:0]       bb_reg;
    logic [DEC_W-1:0]      bx_reg;
    logic [DEC_W-1:0]      ay_reg;
    logic [DEC_W-1:0]      p0_reg;
    logic [DEC_W-1:0]      p1_reg;
    logic [DEC_W-1:0]      p2_reg;

    // result payload registers
    logic [POINT_W-1:0]    px_reg, px_next;
    logic [POINT_W-1:0]    py_reg, py_next;
    logic                  pv_reg, pv_next;
    logic                  fp_reg, fp_next;
    logic                  out_load;

    // shared multiplier
    logic [SQ_W-1:0]       mul_a;
    logic [SQ_W-1:0]       mul_b;
    logic [2*SQ_W-1:0]     mul_full;
    logic [MUL_EXT_W-1:0]  mul_ext;
    logic [DEC_W-1:0]      mul_res;

    // derived values
    logic [DEC_W-1:0]      aa_w;
    logic [DEC_W-1:0]      bb_w;
    logic                  dec_pos;
    logic                  y_zero;
    logic                  x_full;
    logic                  out_free;
    logic                  to_region_two;
    logic [DEC_W-1:0]      step_one;
    logic [DEC_W-1:0]      step_two;

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign point_x     = px_reg;
    assign point_y     = py_reg;
    assign point_valid = pv_reg;
    assign final_point = fp_reg;

    // operand select for the shared multiplier
    always_comb
    begin
        case (state_reg)
            S_IDLE:
            begin
                mul_a = SQ_W'(axis_a_reg);
                mul_b = SQ_W'(axis_a_reg);
            end
            S_BB:
            begin
                mul_a = SQ_W'(axis_b_reg);
                mul_b = SQ_W'(axis_b_reg);
            end
            S_AAB:
            begin
                mul_a = aa_reg;
                mul_b = SQ_W'(axis_b_reg);
            end
            S_BX:
            begin
                mul_a = bb_reg;
                mul_b = SQ_W'(cur_x_reg);
            end
            S_AY:
            begin
                mul_a = aa_reg;
                mul_b = SQ_W'(cur_y_reg);
            end
            S_XX:
            begin
                mul_a = SQ_W'(cur_x_reg);
                mul_b = SQ_W'(cur_x_reg);
            end
            S_UU:
            begin
                mul_a = SQ_W'(cur_y_reg - AXIS_WIDTH'(1));
                mul_b = SQ_W'(cur_y_reg - AXIS_WIDTH'(1));
            end
            S_BXX:
            begin
                mul_a = bb_reg;
                mul_b = SQ_W'(p0_reg);
            end
            S_AUU:
            begin
                mul_a = aa_reg;
                mul_b = SQ_W'(p1_reg);
            end
            S_AABB:
            begin
                mul_a = aa_reg;
                mul_b = bb_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // product, kept modulo the decision width
    assign mul_full = mul_a * mul_b;
    assign mul_ext  = MUL_EXT_W'(mul_full);
    assign mul_res  = mul_ext[DEC_W-1:0];

    // helpers for the decision update
    assign aa_w          = DEC_W'(aa_reg);
    assign bb_w          = DEC_W'(bb_reg);
    assign dec_pos       = !decision_reg[DEC_W-1] && (decision_reg != '0);
    assign y_zero        = (cur_y_reg == '0);
    assign x_full        = (cur_x_reg == {AXIS_WIDTH{1'b1}});
    assign out_free      = !out_valid_reg || !out_stall;
    assign to_region_two = (kind_reg == K_STEP) && !region_two_reg && !y_zero
                           && (bx_reg > ay_reg);

    // region one: add 4bb(2x+3), on a positive decision take off 4aa(2y-2)
    assign step_one = dec_pos
        ? decision_reg + (bx_reg << 3) + (bb_w << 3) + (bb_w << 2)
          - (ay_reg << 3) + (aa_w << 3)
        : decision_reg + (bx_reg << 3) + (bb_w << 3) + (bb_w << 2);

    // region two: add 4aa - 8aa(y-1), otherwise also 4bb(2x+2)
    assign step_two = dec_pos
        ? decision_reg + (aa_w << 3) + (aa_w << 2) - (ay_reg << 3)
        : decision_reg + (aa_w << 3) + (aa_w << 2) - (ay_reg << 3)
          + (bx_reg << 3) + (bb_w << 3);

    // sequencer and state update
    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        decision_next   = decision_reg;
        region_two_next = region_two_reg;
        finished_next   = finished_reg;
        out_load        = 1'b0;
        px_next         = '0;
        py_next         = '0;
        pv_next         = 1'b0;
        fp_next         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (restart)
                    begin
                        kind_next  = K_RESTART;
                        state_next = S_BB;
                    end
                    else if (finished_reg)
                    begin
                        kind_next  = K_EMPTY;
                        state_next = S_PUT;
                    end
                    else if (y_zero)
                    begin
                        kind_next  = K_STEP;
                        state_next = S_PUT;
                    end
                    else
                    begin
                        kind_next  = K_STEP;
                        state_next = S_BB;
                    end
                end
            end
            S_BB:
            begin
                state_next = (kind_reg == K_RESTART) ? S_AAB : S_BX;
            end
            S_AAB:
            begin
                state_next = S_PUT;
            end
            S_BX:
            begin
                state_next = S_AY;
            end
            S_AY:
            begin
                state_next = S_PUT;
            end
            S_PUT:
            begin
                if (to_region_two)
                begin
                    state_next = S_XX;
                end
                else if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                    case (kind_reg)
                        K_RESTART:
                        begin
                            cur_x_next      = '0;
                            cur_y_next      = axis_b_reg;
                            decision_next   = (bb_w << 2) - (p2_reg << 2) + aa_w;
                            region_two_next = 1'b0;
                            finished_next   = 1'b0;
                        end
                        K_STEP:
                        begin
                            px_next = POINT_W'(cur_x_reg);
                            py_next = POINT_W'(cur_y_reg);
                            pv_next = 1'b1;
                            fp_next = y_zero;
                            if (y_zero)
                            begin
                                finished_next = 1'b1;
                            end
                            else if (!region_two_reg)
                            begin
                                decision_next = step_one;
                                if (dec_pos)
                                begin
                                    cur_y_next = cur_y_reg - AXIS_WIDTH'(1);
                                end
                                if (!x_full)
                                begin
                                    cur_x_next = cur_x_reg + AXIS_WIDTH'(1);
                                end
                            end
                            else
                            begin
                                decision_next = step_two;
                                cur_y_next    = cur_y_reg - AXIS_WIDTH'(1);
                                if (!dec_pos && !x_full)
                                begin
                                    cur_x_next = cur_x_reg + AXIS_WIDTH'(1);
                                end
                            end
                        end
                        default:
                        begin
                            // beat after the ellipse ended: empty result
                        end
                    endcase
                end
            end
            S_XX:
            begin
                state_next = S_UU;
            end
            S_UU:
            begin
                state_next = S_BXX;
            end
            S_BXX:
            begin
                state_next = S_AUU;
            end
            S_AUU:
            begin
                state_next = S_AABB;
            end
            S_AABB:
            begin
                state_next = S_R2;
            end
            S_R2:
            begin
                // bb(2x+1)^2 + 4aa(y-1)^2 - 4aabb
                decision_next   = (p0_reg << 2) + (bx_reg << 2) + bb_w
                                  + (p1_reg << 2) - (p2_reg << 2);
                region_two_next = 1'b1;
                state_next      = S_PUT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output beat holds until taken
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control, configuration and ellipse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_a_reg     <= AXIS_WIDTH'(mer_pkg::SEMI_AXIS_X_RESET);
            axis_b_reg     <= AXIS_WIDTH'(mer_pkg::SEMI_AXIS_Y_RESET);
            state_reg      <= S_IDLE;
            kind_reg       <= K_EMPTY;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            decision_reg   <= '0;
            region_two_reg <= 1'b0;
            finished_reg   <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == mer_pkg::REG_SEMI_AXIS_X))
            begin
                axis_a_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == mer_pkg::REG_SEMI_AXIS_Y))
            begin
                axis_b_reg <= cfg_data;
            end
            state_reg      <= state_next;
            kind_reg       <= kind_next;
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            decision_reg   <= decision_next;
            region_two_reg <= region_two_next;
            finished_reg   <= finished_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // multiplier results, one per state
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:  aa_reg <= SQ_W'(mul_res);
            S_BB:    bb_reg <= SQ_W'(mul_res);
            S_AAB:   p2_reg <= mul_res;
            S_BX:    bx_reg <= mul_res;
            S_AY:    ay_reg <= mul_res;
            S_XX:    p0_reg <= mul_res;
            S_UU:    p1_reg <= mul_res;
            S_BXX:   p0_reg <= mul_res;
            S_AUU:   p1_reg <= mul_res;
            S_AABB:  p2_reg <= mul_res;
            default:
            begin
                // no product captured
            end
        endcase
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
            pv_reg <= pv_next;
            fp_reg <= fp_next;
        end
    end

    // checks
    `MER_ASSERT_IMPLY(a_final_on_axis, out_valid && final_point,
                      point_valid && (point_y == '0))
    `MER_ASSERT_IMPLY(a_empty_is_zero, out_valid && !point_valid,
                      (point_x == '0) && (point_y == '0) && !final_point)
    `MER_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, state_reg != S_IDLE)
    `MER_ASSERT_IMPLY(a_region_switch_once, state_reg == S_R2, !region_two_reg)

endmodule

`default_nettype wire

### tb/sv/ellipse_point_checker.sv
// scoreboard for the midpoint ellipse rasterizer: predicts each point beat and compares
// depends on mer_pkg; watches the config port and both channels of the block
`timescale 1ns / 1ps

module ellipse_point_checker #(
    parameter int AXIS_WIDTH = mer_pkg::AXIS_WIDTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mer_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [AXIS_WIDTH-1:0]         cfg_data,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic                          restart,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [mer_pkg::POINT_W-1:0]   point_x,
    input  logic [mer_pkg::POINT_W-1:0]   point_y,
    input  logic                          point_valid,
    input  logic                          final_point,
    output int                            points_due,
    output int                            mismatches
);

    typedef struct packed {
        logic [mer_pkg::POINT_W-1:0] x;
        logic [mer_pkg::POINT_W-1:0] y;
        logic                        valid;
        logic                        last;
    } plot_point_t;

    localparam logic [63:0] AXIS_MAX = (64'd1 << AXIS_WIDTH) - 64'd1;

    // semi-axes as the block sees them
    logic [AXIS_WIDTH-1:0]     axis_a;
    logic [AXIS_WIDTH-1:0]     axis_b;

    // tracer state
    logic [AXIS_WIDTH-1:0]     cur_x;
    logic [AXIS_WIDTH-1:0]     cur_y;
    logic [mer_pkg::DEC_W-1:0] decision;
    logic                      region_two;
    logic                      done;

    plot_point_t pending_points[$];
    int          fail_cnt;

    function automatic bit dec_above_zero(input logic [mer_pkg::DEC_W-1:0] d);
        return !d[mer_pkg::DEC_W-1] && (d != '0);
    endfunction

    // one midpoint iteration, returns the point beat the block owes for this input
    function automatic plot_point_t next_plot_point(input logic restart_bit);
        logic [63:0] a, b, aa, bb, x64, y64, tx, ty, nxt, dec64;
        plot_point_t pt;
        a   = 64'(axis_a);
        b   = 64'(axis_b);
        aa  = a * a;
        bb  = b * b;
        pt  = '0;
        if (restart_bit)
        begin
            nxt        = 4 * bb - 4 * aa * b + aa;
            cur_x      = '0;
            cur_y      = axis_b;
            decision   = nxt[mer_pkg::DEC_W-1:0];
            region_two = 1'b0;
            done       = 1'b0;
            return pt;
        end
        if (done)
            return pt;

        // hand over to region two once the slope passes -1
        if (!region_two && !(bb * 64'(cur_x) <= aa * 64'(cur_y)))
        begin
            tx         = 2 * 64'(cur_x) + 1;
            ty         = 64'(cur_y) - 1;
            nxt        = bb * tx * tx + 4 * aa * ty * ty - 4 * aa * bb;
            region_two = 1'b1;
            decision   = nxt[mer_pkg::DEC_W-1:0];
        end

        x64      = 64'(cur_x);
        y64      = 64'(cur_y);
        pt.x     = x64[mer_pkg::POINT_W-1:0];
        pt.y     = y64[mer_pkg::POINT_W-1:0];
        pt.valid = 1'b1;
        pt.last  = (y64 == 0);
        if (pt.last)
        begin
            done = 1'b1;
            return pt;
        end

        dec64 = 64'(decision);
        if (!region_two)
        begin
            nxt = dec64 + 4 * bb * (2 * x64 + 3);
            if (dec_above_zero(decision))
            begin
                nxt   = nxt - 4 * aa * (2 * y64 - 2);
                cur_y = cur_y - AXIS_WIDTH'(1);
            end
            decision = nxt[mer_pkg::DEC_W-1:0];
            if (x64 < AXIS_MAX)
                cur_x = cur_x + AXIS_WIDTH'(1);
        end
        else
        begin
            nxt = dec64 + 4 * aa - 8 * aa * (y64 - 1);
            if (!dec_above_zero(decision))
            begin
                nxt = nxt + 4 * bb * (2 * x64 + 2);
                if (x64 < AXIS_MAX)
                    cur_x = cur_x + AXIS_WIDTH'(1);
            end
            decision = nxt[mer_pkg::DEC_W-1:0];
            cur_y    = cur_y - AXIS_WIDTH'(1);
        end
        return pt;
    endfunction

    function automatic void check_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            fail_cnt++;
        end
    endfunction

    // predict on input beats, track config writes, compare on output beats
    always @(posedge clk or negedge rst_n)
    begin
        plot_point_t exp_pt;
        if (!rst_n)
        begin
            axis_a     = AXIS_WIDTH'(mer_pkg::SEMI_AXIS_X_RESET);
            axis_b     = AXIS_WIDTH'(mer_pkg::SEMI_AXIS_Y_RESET);
            cur_x      = '0;
            cur_y      = '0;
            decision   = '0;
            region_two = 1'b0;
            done       = 1'b1;
            fail_cnt   = 0;
            pending_points.delete();
            points_due <= 0;
            mismatches <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                pending_points.push_back(next_plot_point(restart));

            if (cfg_we)
            begin
                case (cfg_index)
                    mer_pkg::REG_SEMI_AXIS_X: axis_a = cfg_data;
                    mer_pkg::REG_SEMI_AXIS_Y: axis_b = cfg_data;
                    default: ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                if (pending_points.size() == 0)
                begin
                    $error("point beat with nothing expected: x %0d y %0d", point_x, point_y);
                    fail_cnt++;
                end
                else
                begin
                    exp_pt = pending_points.pop_front();
                    check_field("point_x", exp_pt.x, point_x);
                    check_field("point_y", exp_pt.y, point_y);
                    check_field("point_valid", exp_pt.valid, point_valid);
                    check_field("final_point", exp_pt.last, final_point);
                end
            end

            points_due <= pending_points.size();
            mismatches <= fail_cnt;
        end
    end

endmodule

### tb/sv/midpoint_ellipse_rasterizer_top_test.sv
// top of the ellipse rasterizer bench: clock, reset, config writes, beat traffic, verdict
// depends on mer_pkg, midpoint_ellipse_rasterizer_top and ellipse_point_checker
`timescale 1ns / 1ps

module midpoint_ellipse_rasterizer_top_test;

    localparam int AW          = mer_pkg::AXIS_WIDTH_DEFAULT;
    localparam int ITEM_TARGET = 1300;
    localparam int TICK_CAP    = 120;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_we;
    logic [mer_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [AW-1:0]                 cfg_data;
    logic                          in_valid;
    logic                          in_stall;
    logic                          restart;
    logic                          out_valid;
    logic                          out_stall;
    logic [mer_pkg::POINT_W-1:0]   point_x;
    logic [mer_pkg::POINT_W-1:0]   point_y;
    logic                          point_valid;
    logic                          final_point;

    int points_due;
    int mismatches;
    int items_sent = 0;
    int burst_left = 0;
    bit hold_done  = 1'b0;

    midpoint_ellipse_rasterizer_top #(
        .AXIS_WIDTH(AW)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .restart    (restart),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_valid(point_valid),
        .final_point(final_point)
    );

    ellipse_point_checker #(
        .AXIS_WIDTH(AW)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .restart    (restart),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_valid(point_valid),
        .final_point(final_point),
        .points_due (points_due),
        .mismatches (mismatches)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // one input beat, then, at the end of a burst, an optional idle gap
    task automatic send_beat(input logic restart_bit);
        int gap;
        restart  <= restart_bit;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        items_sent++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // wait until every point beat is back and the block has gone quiet
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (points_due != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic load_axes(input int a, input int b);
        cfg_we    <= 1'b1;
        cfg_index <= mer_pkg::REG_SEMI_AXIS_X;
        cfg_data  <= AW'(a);
        @(posedge clk);
        cfg_index <= mer_pkg::REG_SEMI_AXIS_Y;
        cfg_data  <= AW'(b);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // new axes, optional restart, then a run of beats, each a restart with restart_pct percent odds
    task automatic run_phase(input int a, input int b, input bit fresh, input int ticks,
                             input int restart_pct);
        settle();
        load_axes(a, b);
        if (fresh)
            send_beat(1'b1);
        for (int i = 0; i < ticks; i++)
            send_beat($urandom_range(0, 99) < restart_pct);
    endtask

    // receiver: stall patterns of varying density, one long hold to back up the block
    initial
    begin
        int span;
        int mode;
        out_stall <= 1'b0;
        forever
        begin
            if (!hold_done && items_sent >= 300)
            begin
                hold_done = 1'b1;
                @(posedge clk);
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                span = $urandom_range(10, 80);
                mode = $urandom_range(0, 3);
                repeat (span)
                begin
                    @(posedge clk);
                    case (mode)
                        0:       out_stall <= 1'b0;
                        1:       out_stall <= ($urandom_range(0, 3) == 0);
                        2:       out_stall <= ($urandom_range(0, 3) != 0);
                        default: out_stall <= 1'($urandom_range(0, 1));
                    endcase
                end
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        int a;
        int b;
        int r;
        int ticks;
        int est;
        int phase_no;
        bit fresh;

        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= mer_pkg::REG_SEMI_AXIS_X;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        restart   <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // nothing to draw after reset
        send_beat(1'b0);
        // reset axes, first points of the 200 x 100 ellipse
        send_beat(1'b1);
        send_beat(1'b0);
        send_beat(1'b0);
        // tiny ellipse run past its end
        run_phase(3, 2, 1'b1, 8, 0);
        // zero horizontal axis: one point then a column
        run_phase(0, 3, 1'b1, 5, 0);
        // zero vertical axis: origin point is final
        run_phase(4, 0, 1'b1, 2, 0);

        // random phases, extremes first
        phase_no = 0;
        while (items_sent < ITEM_TARGET)
        begin
            fresh = 1'b1;
            case (phase_no)
                0:
                begin
                    a = 1023;
                    b = 1023;
                end
                1:
                begin
                    a = 1;
                    b = 1023;
                end
                2:
                begin
                    a = 1023;
                    b = 1;
                end
                3:
                begin
                    a = 1;
                    b = 1;
                end
                default:
                begin
                    r = $urandom_range(0, 99);
                    if (r < 75)
                    begin
                        a = $urandom_range(1, 24);
                        b = $urandom_range(1, 24);
                    end
                    else if (r < 90)
                    begin
                        a = $urandom_range(25, 150);
                        b = $urandom_range(1, 150);
                    end
                    else
                    begin
                        a = $urandom_range(151, 1023);
                        b = $urandom_range(1, 1023);
                    end
                    r = $urandom_range(0, 99);
                    if (r < 3)
                        a = 0;
                    else if (r < 6)
                        b = 0;
                    // keep the old ellipse going under new axes
                    fresh = ($urandom_range(0, 99) >= 15);
                end
            endcase
            est = a + b + 2;
            if ($urandom_range(0, 99) < 60)
                ticks = est + $urandom_range(0, 3);
            else
                ticks = $urandom_range(1, est);
            if (ticks > TICK_CAP)
                ticks = TICK_CAP;
            run_phase(a, b, fresh, ticks, (phase_no < 4) ? 0 : 2);
            phase_no++;
        end

        settle();
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
